[sv/psrls_pkg.sv]
// psrls_pkg: shared types and codes for the per-stream ready list scheduler
// no dependencies

package psrls_pkg;

  localparam int unsigned OpBits     = 2;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned StreamBits = 4;
  localparam int unsigned DropBits   = 16;

  typedef enum logic [1:0] {
    OP_ARRIVE   = 2'd0,
    OP_REQUEST  = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_GRANTED    = 3'd2,
    ST_NONE_READY = 3'd3,
    ST_COMPLETED  = 3'd4,
    ST_IGNORED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EXEC,
    FSM_OUT
  } fsm_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dummy_busy;
  } dp_stat_t;

endpackage

[sv/psrls_ctrl.sv]
// psrls_ctrl: sequencing state machine for one beat at a time
// depends on psrls_pkg

module psrls_ctrl
  import psrls_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = FSM_READ;
      FSM_READ: state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_OUT;
      // wait only while the output register is still occupied
      FSM_OUT:  if (!out_valid_q || out_ready_i) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      FSM_EXEC: cmd_o.exec = 1'b1;
      FSM_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
    if (stat_i.dummy_busy) cmd_o.exec = cmd_o.exec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/psrls_dp.sv]
// psrls_dp: queues, ready list, marks, drop counters and result register
// depends on psrls_pkg

module psrls_dp
  import psrls_pkg::*;
#(
  parameter int unsigned STREAMS     = 16,
  parameter int unsigned QUEUE_DEPTH = 3,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_stat_t               stat_o,
  input  logic [OpBits-1:0]      op_i,
  input  logic [StreamBits-1:0]  stream_i,
  input  logic                   frame_type_i,
  input  logic [HANDLE_BITS-1:0] frame_handle_i,
  input  logic [StreamBits-1:0]  sel_audio_i,
  output logic [StatusBits-1:0]  status_o,
  output logic [StreamBits-1:0]  out_stream_o,
  output logic                   out_type_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   deliver_o,
  output logic [DropBits-1:0]    drops_o
);

  localparam int unsigned SB    = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned QB    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FB    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CB    = $clog2(STREAMS + 1);
  localparam int unsigned Words = STREAMS * QUEUE_DEPTH;
  localparam int unsigned AB    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned EW    = HANDLE_BITS + 1;

  // frame memory, one read and one write port
  logic [EW-1:0] mem [Words];
  logic [EW-1:0] mem_rd_q;
  // ready list memory
  logic [SB-1:0] rl_mem [STREAMS];
  logic [SB-1:0] rl_rd_q;

  logic [QB-1:0]       head_q [STREAMS];
  logic [FB-1:0]       fill_q [STREAMS];
  logic [DropBits-1:0] drop_q [STREAMS];
  logic [STREAMS-1:0]  rdy_q, fl_q;
  logic [SB-1:0]       rhead_q;
  logic [CB-1:0]       rcount_q;

  // captured beat
  op_e                  op_q;
  logic [StreamBits-1:0] s_q;
  logic                  ty_q;
  logic [HANDLE_BITS-1:0] h_q;

  logic [StatusBits-1:0]  r_status_q;
  logic [StreamBits-1:0]  r_stream_q;
  logic                   r_type_q, r_del_q;
  logic [HANDLE_BITS-1:0] r_handle_q;
  logic [DropBits-1:0]    r_drops_q;

  logic          s_ok;
  logic [SB-1:0] si;
  assign s_ok = 32'(s_q) < STREAMS;
  assign si   = SB'(s_q);

  function automatic logic [QB-1:0] qwrap(input logic [QB:0] v);
    logic [QB:0] r;
    r = (v >= (QB+1)'(QUEUE_DEPTH)) ? v - (QB+1)'(QUEUE_DEPTH) : v;
    return r[QB-1:0];
  endfunction

  function automatic logic [AB-1:0] addr(input logic [SB-1:0] s, input logic [QB-1:0] q);
    return AB'(32'(s) * QUEUE_DEPTH + 32'(q));
  endfunction

  function automatic logic [SB-1:0] rwrap(input logic [SB:0] v);
    logic [SB:0] r;
    r = (v >= (SB+1)'(STREAMS)) ? v - (SB+1)'(STREAMS) : v;
    return r[SB-1:0];
  endfunction

  // grant stream read from list head
  logic [SB-1:0] g;
  assign g = rl_rd_q;

  // read phase, enabled by the capture command; the list is read at its head
  logic          rd_en;
  logic [AB-1:0] rd_addr;
  assign rd_en = cmd_i.capture;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_e'(op_i);
      s_q  <= stream_i;
      ty_q <= frame_type_i;
      h_q  <= frame_handle_i;
    end
  end

  // read cycle: list head, then the grant stream's head slot
  logic rd2_q;
  always_ff @(posedge clk_i) begin
    if (rd_en) rl_rd_q <= rl_mem[rhead_q];
    rd2_q <= rd_en;
  end
  assign rd_addr = addr(rl_rd_q, head_q[rl_rd_q]);
  always_ff @(posedge clk_i) begin
    if (rd2_q) mem_rd_q <= mem[rd_addr];
  end

  // exec: single state update
  logic arr_ok, arr_full, req_ok, cmp_ok;
  always_comb begin
    arr_ok   = op_q == OP_ARRIVE && s_ok && 32'(fill_q[si]) < QUEUE_DEPTH;
    arr_full = op_q == OP_ARRIVE && s_ok && !arr_ok;
    req_ok   = op_q == OP_REQUEST && rcount_q != '0;
    cmp_ok   = op_q == OP_COMPLETE && s_ok && fl_q[si];
  end

  logic          app;
  logic [SB-1:0] app_s;
  always_comb begin
    app   = 1'b0;
    app_s = si;
    if (arr_ok && !fl_q[si] && !rdy_q[si]) app = 1'b1;
    if (cmp_ok && fill_q[si] != '0 && !rdy_q[si]) app = 1'b1;
    if (32'(rcount_q) >= STREAMS) app = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && arr_ok)
      mem[addr(si, qwrap({1'b0, head_q[si]} + (QB+1)'(fill_q[si])))] <= {ty_q, h_q};
    if (cmd_i.exec && app)
      rl_mem[rwrap({1'b0, rhead_q} + (SB+1)'(rcount_q))] <= app_s;
  end

  logic [DropBits-1:0] drop_nx;
  assign drop_nx = (arr_full && drop_q[si] != '1) ? drop_q[si] + 1'b1 : drop_q[si];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STREAMS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
        drop_q[i] <= '0;
      end
      rdy_q    <= '0;
      fl_q     <= '0;
      rhead_q  <= '0;
      rcount_q <= '0;
    end else if (cmd_i.exec) begin
      if (arr_ok)   fill_q[si] <= fill_q[si] + 1'b1;
      if (arr_full) drop_q[si] <= drop_nx;
      if (req_ok) begin
        rhead_q  <= rwrap({1'b0, rhead_q} + 1'b1);
        rdy_q[g] <= 1'b0;
        fl_q[g]  <= 1'b1;
        if (fill_q[g] != '0) begin
          head_q[g] <= qwrap({1'b0, head_q[g]} + 1'b1);
          fill_q[g] <= fill_q[g] - 1'b1;
        end
      end
      if (cmp_ok) fl_q[si] <= 1'b0;
      if (app) rdy_q[app_s] <= 1'b1;
      rcount_q <= rcount_q + CB'(app) - CB'(req_ok);
    end
  end

  // result latched at exec, moved to output register on load
  logic [StatusBits-1:0]  n_status;
  logic [StreamBits-1:0]  n_stream;
  logic                   n_type, n_del;
  logic [HANDLE_BITS-1:0] n_handle;
  logic [DropBits-1:0]    n_drops;
  always_comb begin
    n_status = ST_IGNORED;
    n_stream = s_q;
    n_type   = 1'b0;
    n_handle = '0;
    n_del    = 1'b0;
    n_drops  = s_ok ? drop_q[si] : '0;
    case (op_q)
      OP_ARRIVE: begin
        n_status = arr_ok ? ST_QUEUED : ST_DROPPED;
        n_drops  = s_ok ? drop_nx : '0;
      end
      OP_REQUEST: begin
        if (!req_ok) begin
          n_status = ST_NONE_READY;
          n_stream = '0;
          n_drops  = '0;
        end else begin
          n_status = ST_GRANTED;
          n_stream = StreamBits'(g);
          n_drops  = drop_q[g];
          if (fill_q[g] != '0) begin
            n_type   = mem_rd_q[EW-1];
            n_handle = mem_rd_q[HANDLE_BITS-1:0];
            n_del    = !n_type || (sel_audio_i == StreamBits'(g));
          end
        end
      end
      OP_COMPLETE: if (cmp_ok) n_status = ST_COMPLETED;
      default: ;
    endcase
  end

  logic [StatusBits+StreamBits+2+HANDLE_BITS+DropBits-1:0] res_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= {n_status, n_stream, n_type, n_del, n_handle, n_drops};
    if (cmd_i.out_load)
      {r_status_q, r_stream_q, r_type_q, r_del_q, r_handle_q, r_drops_q} <= res_q;
  end

  assign stat_o.dummy_busy = 1'b0;
  assign status_o     = r_status_q;
  assign out_stream_o = r_stream_q;
  assign out_type_o   = r_type_q;
  assign out_handle_o = r_handle_q;
  assign deliver_o    = r_del_q;
  assign drops_o      = r_drops_q;

endmodule

[sv/per_stream_ready_list_scheduler_core.sv]
// per_stream_ready_list_scheduler_core: top level, apb register, controller, datapath
// depends on psrls_pkg, psrls_ctrl, psrls_dp
// a beat passes through capture, list read, frame read and update, and output
// load in order, the load waiting while the output register is still occupied;
// a new beat is taken only once the previous one is in the output register
// reset: asynchronous active low, clears marks, fills, drop counters, list
// pointers and the register; frame and list memories are not cleared
module per_stream_ready_list_scheduler_core
  import psrls_pkg::*;
#(
  parameter int unsigned STREAMS     = 16,
  parameter int unsigned QUEUE_DEPTH = 3,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OpBits-1:0]      op_i,
  input  logic [StreamBits-1:0]  stream_i,
  input  logic                   frame_type_i,
  input  logic [HANDLE_BITS-1:0] frame_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [StatusBits-1:0]  status_o,
  output logic [StreamBits-1:0]  out_stream_o,
  output logic                   out_type_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic                   deliver_o,
  output logic [DropBits-1:0]    drops_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // selected audio stream register at byte address zero
  logic [StreamBits-1:0] sel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      sel_q <= pwdata[StreamBits-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, sel_q} : 32'd0;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  psrls_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  psrls_dp #(
    .STREAMS(STREAMS), .QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .op_i, .stream_i, .frame_type_i, .frame_handle_i,
    .sel_audio_i(sel_q),
    .status_o, .out_stream_o, .out_type_o, .out_handle_o, .deliver_o, .drops_o
  );

endmodule
